>>> rtl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg: swap pool frame replacement package
// Field widths, address constants and the page slot rule.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int FRAMES_DEF = 16;
  localparam int SLOTS_DEF  = 32;

  localparam int PID_W   = 4;
  localparam int PAGE_W  = 20;
  localparam int FRAME_W = 4;
  localparam int DEV_W   = 3;
  localparam int SLOT_W  = 5;
  localparam int ADDR_W  = 32;

  localparam logic [ADDR_W-1:0] POOL_BASE   = 32'h2002_0000;
  localparam int                FRAME_SHIFT = 12;
  localparam logic [PAGE_W-1:0] PAGE_BASE   = 20'h8_0000;
  localparam logic [PAGE_W-1:0] STACK_PAGE  = 20'hB_FFFF;
  localparam logic [ADDR_W-1:0] BIT_VALID   = 32'h0000_0200;
  localparam logic [ADDR_W-1:0] BIT_DIRTY   = 32'h0000_0400;

  // The stack page takes the last slot; every other page is an offset from
  // the base of the user area, wrapping at the page width.
  function automatic logic [PAGE_W-1:0] slot_of(input logic [PAGE_W-1:0] page,
                                                input logic [PAGE_W-1:0] last_slot);
    logic [PAGE_W-1:0] slot;
    if (page == STACK_PAGE) begin
      slot = last_slot;
    end else begin
      slot = page - PAGE_BASE;
    end
    return slot;
  endfunction

endpackage

>>> rtl/spf_intf.sv
// ----------------------------------------------------------------------------
// spf_intf: page fault and result channels
// Valid/ready channels carrying one page fault and one frame allocation.
// ----------------------------------------------------------------------------
interface spf_in_if
  import spf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PID_W-1:0]  process_id;
  logic [PAGE_W-1:0] virtual_page;

  modport source (output valid, output process_id, output virtual_page, input ready);
  modport sink   (input valid, input process_id, input virtual_page, output ready);
endinterface

interface spf_out_if
  import spf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame;
  logic               evicted;
  logic [DEV_W-1:0]   victim_device;
  logic [SLOT_W-1:0]  victim_slot;
  logic [DEV_W-1:0]   read_device;
  logic [SLOT_W-1:0]  read_slot;
  logic [ADDR_W-1:0]  frame_address;
  logic [ADDR_W-1:0]  entry_low;
  logic               slot_out_of_range;

  modport source (output valid, output frame, output evicted, output victim_device,
                  output victim_slot, output read_device, output read_slot,
                  output frame_address, output entry_low, output slot_out_of_range,
                  input ready);
  modport sink   (input valid, input frame, input evicted, input victim_device,
                  input victim_slot, input read_device, input read_slot,
                  input frame_address, input entry_low, input slot_out_of_range,
                  output ready);
endinterface

>>> rtl/spf_ram.sv
// ----------------------------------------------------------------------------
// spf_ram: simple dual port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/swap_pool_frame_replacement.sv
// ----------------------------------------------------------------------------
// swap_pool_frame_replacement: swap pool frame allocator for page faults
// Picks a frame for each page fault, reports the evicted page and builds
// the new entry-low word.
// ----------------------------------------------------------------------------
//  Channel   Direction  Interface         Contents
//  in_req    sink       spf_in_if         process id, missing virtual page
//  out_rsp   source     spf_out_if        frame, victim, read slot, entry-low
//
//  Each fault passes through ST_IDLE and ST_LOOKUP: the accept cycle runs
//  the free-frame search and reads the owner table, and ST_LOOKUP writes
//  the table back and loads the output register. A new fault is taken
//  while a result waits. The frame-in-use bits and the round-robin pointer
//  clear on reset; the owner table needs no clearing. A stalled output
//  holds the block in ST_LOOKUP.
// ----------------------------------------------------------------------------
module swap_pool_frame_replacement
  import spf_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF,
  parameter int SLOTS  = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  spf_in_if.sink    in_req,
  spf_out_if.source out_rsp
);

  localparam int IDX_W = $clog2(FRAMES);
  localparam int ENT_W = PID_W + PAGE_W;
  localparam logic [IDX_W-1:0]  LAST_FRAME = IDX_W'(FRAMES - 1);
  localparam logic [PAGE_W-1:0] LAST_SLOT  = PAGE_W'(SLOTS - 1);
  localparam logic [PAGE_W-1:0] SLOT_LIMIT = PAGE_W'(SLOTS);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_LOOKUP = 1'b1;

  logic              state_r, state_nxt;
  logic [FRAMES-1:0] used_r, used_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [IDX_W-1:0]  pick_r;
  logic              was_used_r;
  logic [PID_W-1:0]  pid_r;
  logic [PAGE_W-1:0] page_r;

  logic              accept;
  logic              load_out;
  logic              found;
  logic [IDX_W-1:0]  first_free;
  logic [IDX_W-1:0]  pick;
  logic [IDX_W-1:0]  ptr_inc;
  logic [ENT_W-1:0]  ram_rdata;
  logic [PAGE_W-1:0] read_slot_full;
  logic [PAGE_W-1:0] victim_slot_full;
  logic [ADDR_W-1:0] addr;

  logic               out_valid_r;
  logic [FRAME_W-1:0] frame_r;
  logic               evicted_r;
  logic [DEV_W-1:0]   victim_device_r;
  logic [SLOT_W-1:0]  victim_slot_r;
  logic [DEV_W-1:0]   read_device_r;
  logic [SLOT_W-1:0]  read_slot_r;
  logic [ADDR_W-1:0]  frame_address_r;
  logic [ADDR_W-1:0]  entry_low_r;
  logic               oor_r;

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign load_out     = (state_r == ST_LOOKUP) && (!out_valid_r || out_rsp.ready);

  // Lowest free frame.
  always_comb begin
    found      = 1'b0;
    first_free = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        found      = 1'b1;
        first_free = IDX_W'(i);
      end
    end
  end

  assign ptr_inc = (ptr_r == LAST_FRAME) ? '0 : ptr_r + 1'b1;
  assign pick    = found ? first_free : ptr_r;

  always_comb begin
    ptr_nxt  = ptr_r;
    used_nxt = used_r;
    if (accept) begin
      // The pointer moves on whenever the chosen frame is the one it names.
      if (pick == ptr_r) begin
        ptr_nxt = ptr_inc;
      end
      used_nxt[pick] = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pick_r     <= pick;
      was_used_r <= !found;
      pid_r      <= in_req.process_id;
      page_r     <= in_req.virtual_page;
    end
  end

  // Owner and page of each frame; read on accept, written back
  // in ST_LOOKUP, so consecutive faults never overlap on an entry.
  spf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (FRAMES)
  ) u_owner_ram (
    .clk   (clk),
    .we    (load_out),
    .waddr (pick_r),
    .wdata ({pid_r, page_r}),
    .re    (accept),
    .raddr (pick),
    .rdata (ram_rdata)
  );

  assign read_slot_full   = slot_of(page_r, LAST_SLOT);
  assign victim_slot_full = slot_of(ram_rdata[PAGE_W-1:0], LAST_SLOT);
  assign addr             = POOL_BASE + (ADDR_W'(pick_r) << FRAME_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      frame_r         <= FRAME_W'(pick_r);
      evicted_r       <= was_used_r;
      victim_device_r <= was_used_r ? DEV_W'(ram_rdata[ENT_W-1:PAGE_W] - 1'b1) : '0;
      victim_slot_r   <= was_used_r ? victim_slot_full[SLOT_W-1:0] : '0;
      read_device_r   <= DEV_W'(pid_r - 1'b1);
      read_slot_r     <= read_slot_full[SLOT_W-1:0];
      frame_address_r <= addr;
      entry_low_r     <= addr | BIT_VALID | BIT_DIRTY;
      oor_r           <= (read_slot_full >= SLOT_LIMIT);
    end
  end

  assign out_rsp.valid             = out_valid_r;
  assign out_rsp.frame             = frame_r;
  assign out_rsp.evicted           = evicted_r;
  assign out_rsp.victim_device     = victim_device_r;
  assign out_rsp.victim_slot       = victim_slot_r;
  assign out_rsp.read_device       = read_device_r;
  assign out_rsp.read_slot         = read_slot_r;
  assign out_rsp.frame_address     = frame_address_r;
  assign out_rsp.entry_low         = entry_low_r;
  assign out_rsp.slot_out_of_range = oor_r;

endmodule

>>> tb/spf_frame_checker.sv
// ----------------------------------------------------------------------------
// spf_frame_checker: result checker for the swap pool frame allocator
// Watches both channels, keeps its own copy of the frame table and the
// round-robin pointer, predicts one allocation per accepted fault and
// compares every returned allocation with the oldest prediction.
// ----------------------------------------------------------------------------
module spf_frame_checker
  import spf_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF,
  parameter int SLOTS  = SLOTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  spf_in_if    in_mon,
  spf_out_if   out_mon,
  output int   errors,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               evicted;
    logic [DEV_W-1:0]   victim_device;
    logic [SLOT_W-1:0]  victim_slot;
    logic [DEV_W-1:0]   read_device;
    logic [SLOT_W-1:0]  read_slot;
    logic [ADDR_W-1:0]  frame_address;
    logic [ADDR_W-1:0]  entry_low;
    logic               slot_out_of_range;
  } frame_alloc_t;

  frame_alloc_t      pending_allocs[$];
  logic              frame_busy[FRAMES];
  logic [PID_W-1:0]  frame_pid[FRAMES];
  logic [PAGE_W-1:0] frame_vpn[FRAMES];
  int                rr_ptr;

  function automatic logic [PAGE_W-1:0] vpn_to_slot(input logic [PAGE_W-1:0] vpn);
    if (vpn == STACK_PAGE) begin
      return PAGE_W'(SLOTS - 1);
    end
    return vpn - PAGE_BASE;
  endfunction

  task automatic allocate_frame(input logic [PID_W-1:0] pid, input logic [PAGE_W-1:0] vpn);
    frame_alloc_t      alloc;
    int                pick;
    logic [PAGE_W-1:0] slot;
    logic [ADDR_W-1:0] base;
    pick = -1;
    for (int i = 0; i < FRAMES; i++) begin
      if (!frame_busy[i] && pick < 0) begin
        pick = i;
      end
    end
    // A free frame moves the pointer only when it is the frame the pointer
    // names; with no free frame the pointer's frame is always taken.
    if (pick >= 0) begin
      if (pick == rr_ptr) begin
        rr_ptr = (rr_ptr + 1 >= FRAMES) ? 0 : rr_ptr + 1;
      end
    end else begin
      pick   = rr_ptr;
      rr_ptr = (rr_ptr + 1 >= FRAMES) ? 0 : rr_ptr + 1;
    end
    alloc = '0;
    if (frame_busy[pick]) begin
      alloc.evicted       = 1'b1;
      alloc.victim_device = DEV_W'(frame_pid[pick] - 1'b1);
      alloc.victim_slot   = SLOT_W'(vpn_to_slot(frame_vpn[pick]));
    end
    frame_busy[pick] = 1'b1;
    frame_pid[pick]  = pid;
    frame_vpn[pick]  = vpn;
    slot = vpn_to_slot(vpn);
    base = POOL_BASE + (ADDR_W'(pick) << FRAME_SHIFT);
    alloc.frame             = FRAME_W'(pick);
    alloc.read_device       = DEV_W'(pid - 1'b1);
    alloc.read_slot         = SLOT_W'(slot);
    alloc.frame_address     = base;
    alloc.entry_low         = base | BIT_VALID | BIT_DIRTY;
    alloc.slot_out_of_range = (slot >= SLOTS);
    pending_allocs.push_back(alloc);
  endtask

  always @(posedge clk) begin
    frame_alloc_t got;
    frame_alloc_t want;
    if (!rst_n) begin
      pending_allocs.delete();
      for (int i = 0; i < FRAMES; i++) begin
        frame_busy[i] = 1'b0;
      end
      rr_ptr      = 0;
      errors      = 0;
      outstanding = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.frame, out_mon.evicted, out_mon.victim_device, out_mon.victim_slot,
                out_mon.read_device, out_mon.read_slot, out_mon.frame_address,
                out_mon.entry_low, out_mon.slot_out_of_range};
        if (pending_allocs.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: allocation with no fault outstanding: frame %0d", $realtime,
                     got.frame);
          end
        end else begin
          want = pending_allocs.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: allocation mismatch", $realtime);
              $display("  expected frame %0d evict %0b vdev %0d vslot %0d rdev %0d rslot %0d",
                       want.frame, want.evicted, want.victim_device, want.victim_slot,
                       want.read_device, want.read_slot);
              $display("           addr %h entry %h oor %0b",
                       want.frame_address, want.entry_low, want.slot_out_of_range);
              $display("  actual   frame %0d evict %0b vdev %0d vslot %0d rdev %0d rslot %0d",
                       got.frame, got.evicted, got.victim_device, got.victim_slot,
                       got.read_device, got.read_slot);
              $display("           addr %h entry %h oor %0b",
                       got.frame_address, got.entry_low, got.slot_out_of_range);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        allocate_frame(in_mon.process_id, in_mon.virtual_page);
      end
      outstanding = pending_allocs.size();
    end
  end

endmodule

>>> tb/swap_pool_frame_replacement_test.sv
// ----------------------------------------------------------------------------
// swap_pool_frame_replacement_test: testbench top for the frame allocator
// Drives directed and random page faults through four pacing phases, with
// random source gaps and sink stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module swap_pool_frame_replacement_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spf_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_FAULTS = 485;

  logic clk = 1'b0;
  logic rst_n;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   cycles    = 0;
  int   errors;
  int   outstanding;

  spf_in_if  in_req();
  spf_out_if out_rsp();

  swap_pool_frame_replacement uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  spf_frame_checker alloc_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_req),
    .out_mon     (out_rsp),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Entered and left at a falling edge; valid stays high between
  // back-to-back transactions.
  task automatic raise_fault(input logic [PID_W-1:0] pid, input logic [PAGE_W-1:0] vpn);
    while ($urandom_range(99) < idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid        <= 1'b1;
    in_req.process_id   <= pid;
    in_req.virtual_page <= vpn;
    do @(posedge clk); while (!in_req.ready);
    @(negedge clk);
  endtask

  initial begin
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] vpn;
    rst_n               = 1'b0;
    in_req.valid        = 1'b0;
    in_req.process_id   = '0;
    in_req.virtual_page = '0;
    out_rsp.ready       = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: slot extremes, the stack page, wrapped and out-of-range
    // pages, process ids outside 1..8, then enough faults to fill the pool
    // and evict the unusual entries.
    raise_fault(4'd1,  20'h80000);
    raise_fault(4'd8,  20'h8001F);
    raise_fault(4'd0,  STACK_PAGE);
    raise_fault(4'd15, 20'h80020);
    raise_fault(4'd2,  20'h7FFFF);
    raise_fault(4'd3,  20'h00000);
    raise_fault(4'd4,  20'hFFFFF);
    raise_fault(4'd5,  20'hBFFFE);
    raise_fault(4'd9,  20'h80010);
    raise_fault(4'd6,  20'h80001);
    raise_fault(4'd7,  20'h8000F);
    raise_fault(4'd1,  20'h80002);
    raise_fault(4'd2,  20'h80003);
    raise_fault(4'd3,  20'h80004);
    raise_fault(4'd4,  20'h80005);
    raise_fault(4'd5,  20'h80006);
    raise_fault(4'd6,  20'h80007);
    raise_fault(4'd7,  20'h80008);
    raise_fault(4'd8,  20'h80009);
    raise_fault(4'd1,  STACK_PAGE);
    raise_fault(4'd2,  20'h8000A);
    raise_fault(4'd3,  20'h5A5A5);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      for (int n = 0; n < PHASE_FAULTS; n++) begin
        if ($urandom_range(99) < 85) begin
          pid = PID_W'($urandom_range(8, 1));
          vpn = ($urandom_range(15) == 0) ? STACK_PAGE
                                          : PAGE_W'(PAGE_BASE + $urandom_range(SLOTS_DEF - 1));
        end else if ($urandom_range(1) == 0) begin
          pid = PID_W'($urandom_range(15));
          vpn = PAGE_W'($urandom);
        end else begin
          // Just either side of the user area and of the stack page.
          pid = PID_W'($urandom_range(15));
          vpn = ($urandom_range(1) == 0) ? PAGE_W'(PAGE_BASE + $urandom_range(40) - 4)
                                         : PAGE_W'(STACK_PAGE + $urandom_range(2) - 1);
        end
        raise_fault(pid, vpn);
      end
    end

    in_req.valid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
